// File: sv/sluf_pkg.sv
// Shared types, constants and the arctangent table of the smoothed look-at follower.
package sluf_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Table and datapath widths
  localparam int TAB_IDX_W = 5;   // 24 table entries
  localparam int VEC_W     = 33;  // vector components into the CORDIC
  localparam int CXY_W     = 36;  // CORDIC x/y working width (gain headroom)
  localparam int ACC_W     = 34;  // Q2.30 angle accumulator with headroom

  localparam logic signed [ACC_W-1:0] PI_HALF_Q30 = 34'sd1686629713;
  localparam logic signed [15:0]      ANGLE_MAX   = 16'sd25736;

  localparam logic [16:0] FRAC_ONE   = 17'd65536;
  localparam logic [16:0] FRAC_RESET = 17'd6554;

  typedef enum logic [1:0] {
    CFG_OFFSET_X        = 2'd0,
    CFG_OFFSET_Y        = 2'd1,
    CFG_OFFSET_Z        = 2'd2,
    CFG_FOLLOW_FRACTION = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    LERP_X     = 3'd0,
    LERP_Y     = 3'd1,
    LERP_Z     = 3'd2,
    LERP_YAW   = 3'd3,
    LERP_PITCH = 3'd4
  } lerp_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LMUL,
    ST_LADD,
    ST_DIFF,
    ST_YAW_GO,
    ST_YAW_RUN,
    ST_SHRINK,
    ST_SQ_X,
    ST_SQ_Z,
    ST_SQ_ADD,
    ST_SQRT_RUN,
    ST_PITCH_GO,
    ST_PITCH_RUN,
    ST_DONE
  } sluf_state_e;

  // atan(2^-i) in Q2.30, rounded
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      5'd11:   v = 34'sd524288;
      5'd12:   v = 34'sd262144;
      5'd13:   v = 34'sd131072;
      5'd14:   v = 34'sd65536;
      5'd15:   v = 34'sd32768;
      5'd16:   v = 34'sd16384;
      5'd17:   v = 34'sd8192;
      5'd18:   v = 34'sd4096;
      5'd19:   v = 34'sd2048;
      5'd20:   v = 34'sd1024;
      5'd21:   v = 34'sd512;
      5'd22:   v = 34'sd256;
      5'd23:   v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/sluf_cordic.sv
// Iterative CORDIC vectoring unit: atan2(y, x) in Q3.13, one rotation per cycle.
module sluf_cordic #(
  parameter int unsigned STEPS = sluf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [sluf_pkg::VEC_W-1:0]   y_i,
  input  logic signed [sluf_pkg::VEC_W-1:0]   x_i,
  output logic                                done_o,
  output logic signed [15:0]                  angle_o
);
  import sluf_pkg::*;

  localparam int CNT_W = $clog2(STEPS);

  logic signed [CXY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic                    zero_q, zero_d;

  logic signed [CXY_W-1:0] x_ext, y_ext, xs, ys;
  logic signed [ACC_W-1:0] tab, rnd;
  logic signed [16:0]      r;
  logic signed [15:0]      r_clamped;

  assign x_ext = {{(CXY_W-VEC_W){x_i[VEC_W-1]}}, x_i};
  assign y_ext = {{(CXY_W-VEC_W){y_i[VEC_W-1]}}, y_i};
  assign xs    = x_q >>> cnt_q;
  assign ys    = y_q >>> cnt_q;
  assign tab   = atan_entry(TAB_IDX_W'(cnt_q));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    if (start_i) begin
      zero_d = (x_i == '0) && (y_i == '0);
      busy_d = 1'b1;
      cnt_d  = '0;
      // left half plane: quarter turn first
      if (x_i[VEC_W-1]) begin
        if (!y_i[VEC_W-1]) begin
          x_d   = y_ext;
          y_d   = -x_ext;
          acc_d = PI_HALF_Q30;
        end else begin
          x_d   = -y_ext;
          y_d   = x_ext;
          acc_d = -PI_HALF_Q30;
        end
      end else begin
        x_d   = x_ext;
        y_d   = y_ext;
        acc_d = '0;
      end
    end else if (busy_q) begin
      if (!y_q[CXY_W-1]) begin
        x_d   = x_q + ys;
        y_d   = y_q - xs;
        acc_d = acc_q + tab;
      end else begin
        x_d   = x_q - ys;
        y_d   = y_q + xs;
        acc_d = acc_q - tab;
      end
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // Q2.30 -> Q3.13 with round half up, then clamp
  always_comb begin
    rnd = acc_q + 34'sd65536;
    r   = rnd[ACC_W-1:17];
    if (r > 17'sd25736) begin
      r_clamped = ANGLE_MAX;
    end else if (r < -17'sd25736) begin
      r_clamped = -ANGLE_MAX;
    end else begin
      r_clamped = r[15:0];
    end
  end

  assign angle_o = zero_q ? '0 : r_clamped;
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    zero_q <= zero_d;
  end

endmodule

// File: sv/sluf_isqrt.sv
// Bit-serial integer square root: floor(sqrt(v)) for a 63-bit value, two bits per cycle.
module sluf_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import sluf_pkg::*;

  logic [63:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, val_i};
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == 64'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

endmodule

// File: sv/smoothed_look_at_follower_unit.sv
// Top level of the smoothed look-at follower: camera follow, yaw/pitch look-at, smoothing.
//
//  Channel | Handshake                    | Word
//  --------+------------------------------+-----------------------------------------------
//  cfg     | cfg_we_i (no wait)           | cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_stall_o      | mode_i, target_x_i, target_y_i, target_z_i
//  out     | out_valid_o / out_stall_i    | view_x_o, view_y_o, view_z_o, view_yaw_o,
//          |                              | view_pitch_o
//
//  The two CORDIC passes (one rotation a cycle) and the square root take most of the time;
//  one 33x32 multiplier serves all five lerps and both squares.
//  in_stall_o is high while a word is in work; a result waits in the output register,
//  so the next word can be taken while out_stall_i holds the previous one.
//  Reset clears the camera state, the angles and the registers to their reset values.
module smoothed_look_at_follower_unit #(
  parameter int unsigned CORDIC_STEPS = sluf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] view_x_o,
  output logic signed [31:0] view_y_o,
  output logic signed [31:0] view_z_o,
  output logic signed [15:0] view_yaw_o,
  output logic signed [15:0] view_pitch_o
);
  import sluf_pkg::*;

  // Saturating Q16.16 add for the goal position
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // Magnitude shifted right by two, sign kept
  function automatic logic signed [32:0] shrink2(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    m = m >> 2;
    shrink2 = v[32] ? -$signed(m) : $signed(m);
  endfunction

  // Control
  sluf_state_e state_q, state_d;
  lerp_sel_e   sel_q, sel_d;
  logic        in_acc, out_load, cordic_start, sqrt_start;
  logic        cordic_done, sqrt_done;

  // Registers
  logic signed [31:0] off_x_q, off_y_q, off_z_q;
  logic [16:0]        frac_q;

  // Camera state
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [15:0] yaw_q, pitch_q;

  // Per-word work registers
  logic [16:0]        f_q;
  logic signed [31:0] tx_q, ty_q, tz_q, gx_q, gy_q, gz_q;
  logic signed [32:0] d_x_q, d_y_q, d_z_q;
  logic signed [64:0] prod_q;
  logic [62:0]        sq_q;
  logic [31:0]        h_q;
  logic signed [15:0] yaw_t_q, pitch_t_q;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic signed [15:0] vyaw_q, vpitch_q;

  // Datapath wires
  logic signed [32:0] cur_v, goal_v, diff_v, new_v, ax, az;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p, lerp_rnd, lerp_step;
  logic signed [32:0] cor_y, cor_x;
  logic signed [15:0] cor_angle;
  logic [31:0]        sqrt_root;
  logic [16:0]        f_eff;
  logic               big;

  // ---------------------------------------------------------------------------
  // Lerp operand select: positions first, angles after both CORDIC passes
  always_comb begin
    case (sel_q)
      LERP_X: begin
        cur_v  = {pos_x_q[31], pos_x_q};
        goal_v = {gx_q[31], gx_q};
      end
      LERP_Y: begin
        cur_v  = {pos_y_q[31], pos_y_q};
        goal_v = {gy_q[31], gy_q};
      end
      LERP_Z: begin
        cur_v  = {pos_z_q[31], pos_z_q};
        goal_v = {gz_q[31], gz_q};
      end
      LERP_YAW: begin
        cur_v  = {{17{yaw_q[15]}}, yaw_q};
        goal_v = {{17{yaw_t_q[15]}}, yaw_t_q};
      end
      LERP_PITCH: begin
        cur_v  = {{17{pitch_q[15]}}, pitch_q};
        goal_v = {{17{pitch_t_q[15]}}, pitch_t_q};
      end
      default: begin
        cur_v  = '0;
        goal_v = '0;
      end
    endcase
  end

  assign diff_v = goal_v - cur_v;

  // |d| after the optional shrink fits in 31 bits
  assign ax  = d_x_q[32] ? -d_x_q : d_x_q;
  assign az  = d_z_q[32] ? -d_z_q : d_z_q;
  assign big = (ax[32:31] != 2'b00) || (az[32:31] != 2'b00);

  // Shared multiplier
  always_comb begin
    case (state_q)
      ST_SQ_X: begin
        mul_a = ax;
        mul_b = ax[31:0];
      end
      ST_SQ_Z: begin
        mul_a = az;
        mul_b = az[31:0];
      end
      default: begin
        mul_a = diff_v;
        mul_b = {15'd0, f_q};
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign lerp_rnd  = prod_q + 65'sd32768;
  assign lerp_step = lerp_rnd >>> 16;
  assign new_v     = cur_v + lerp_step[32:0];

  // Snap mode is a lerp with a fraction of one
  assign f_eff = !mode_i ? FRAC_ONE : ((frac_q > FRAC_ONE) ? FRAC_ONE : frac_q);

  // Shared CORDIC: yaw = atan2(dx, dz), pitch = atan2(-dy, h)
  assign cor_y = (state_q == ST_PITCH_GO) ? -d_y_q : d_x_q;
  assign cor_x = (state_q == ST_PITCH_GO) ? {1'b0, h_q} : d_z_q;

  sluf_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .y_i     (cor_y),
    .x_i     (cor_x),
    .done_o  (cordic_done),
    .angle_o (cor_angle)
  );

  sluf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sq_q + prod_q[62:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LMUL;
          sel_d   = LERP_X;
        end
      end
      ST_LMUL: state_d = ST_LADD;
      ST_LADD: begin
        if (sel_q == LERP_Z) begin
          state_d = ST_DIFF;
        end else if (sel_q == LERP_PITCH) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LMUL;
          sel_d   = lerp_sel_e'(sel_q + 3'd1);
        end
      end
      ST_DIFF:   state_d = ST_YAW_GO;
      ST_YAW_GO: state_d = ST_YAW_RUN;
      ST_YAW_RUN: begin
        if (cordic_done) begin
          state_d = ST_SHRINK;
        end
      end
      ST_SHRINK: state_d = ST_SQ_X;
      ST_SQ_X:   state_d = ST_SQ_Z;
      ST_SQ_Z:   state_d = ST_SQ_ADD;
      ST_SQ_ADD: state_d = ST_SQRT_RUN;
      ST_SQRT_RUN: begin
        if (sqrt_done) begin
          state_d = ST_PITCH_GO;
        end
      end
      ST_PITCH_GO: state_d = ST_PITCH_RUN;
      ST_PITCH_RUN: begin
        if (cordic_done) begin
          state_d = ST_LMUL;
          sel_d   = LERP_YAW;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    in_acc       = in_valid_i && (state_q == ST_IDLE);
    cordic_start = (state_q == ST_YAW_GO) || (state_q == ST_PITCH_GO);
    sqrt_start   = (state_q == ST_SQ_ADD);
    out_load     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= LERP_X;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
      frac_q  <= FRAC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_X:        off_x_q <= cfg_data_i;
        CFG_OFFSET_Y:        off_y_q <= cfg_data_i;
        CFG_OFFSET_Z:        off_z_q <= cfg_data_i;
        CFG_FOLLOW_FRACTION: frac_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Camera state: written only by the lerp add step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      yaw_q   <= '0;
      pitch_q <= '0;
    end else if (state_q == ST_LADD) begin
      case (sel_q)
        LERP_X:     pos_x_q <= new_v[31:0];
        LERP_Y:     pos_y_q <= new_v[31:0];
        LERP_Z:     pos_z_q <= new_v[31:0];
        LERP_YAW:   yaw_q   <= new_v[15:0];
        LERP_PITCH: pitch_q <= new_v[15:0];
        default: ;
      endcase
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_q  <= f_eff;
      tx_q <= target_x_i;
      ty_q <= target_y_i;
      tz_q <= target_z_i;
      gx_q <= sat_add(target_x_i, off_x_q);
      gy_q <= sat_add(target_y_i, off_y_q);
      gz_q <= sat_add(target_z_i, off_z_q);
    end
    case (state_q)
      ST_LMUL, ST_SQ_X: prod_q <= mul_p;
      ST_SQ_Z: begin
        sq_q   <= prod_q[62:0];
        prod_q <= mul_p;
      end
      ST_DIFF: begin
        d_x_q <= {tx_q[31], tx_q} - {pos_x_q[31], pos_x_q};
        d_y_q <= {ty_q[31], ty_q} - {pos_y_q[31], pos_y_q};
        d_z_q <= {tz_q[31], tz_q} - {pos_z_q[31], pos_z_q};
      end
      ST_YAW_RUN: begin
        if (cordic_done) begin
          yaw_t_q <= cor_angle;
        end
      end
      ST_SHRINK: begin
        // keeps dx^2 + dz^2 below 2^63
        if (big) begin
          d_x_q <= shrink2(d_x_q);
          d_y_q <= shrink2(d_y_q);
          d_z_q <= shrink2(d_z_q);
        end
      end
      ST_SQRT_RUN: begin
        if (sqrt_done) begin
          h_q <= sqrt_root;
        end
      end
      ST_PITCH_RUN: begin
        if (cordic_done) begin
          pitch_t_q <= cor_angle;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      vx_q     <= pos_x_q;
      vy_q     <= pos_y_q;
      vz_q     <= pos_z_q;
      vyaw_q   <= yaw_q;
      vpitch_q <= pitch_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign view_x_o     = vx_q;
  assign view_y_o     = vy_q;
  assign view_z_o     = vz_q;
  assign view_yaw_o   = vyaw_q;
  assign view_pitch_o = vpitch_q;

endmodule

// File: sv/sluf_checker.sv
// Port-level checks for the smoothed look-at follower, bound to the top level.
module sluf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input logic signed [31:0] view_x_i,
  input logic signed [15:0] view_yaw_i,
  input logic signed [15:0] view_pitch_i
);

  // A taken word keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |=> in_stall_i)
    else $error("input taken but block not busy next cycle");

  // Block only goes idle again by handing a result to the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_i) |-> out_valid_i)
    else $error("block went idle without a result");

  // Angles stay inside +-pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (view_yaw_i <= 16'sd25736 && view_yaw_i >= -16'sd25736 &&
                     view_pitch_i <= 16'sd25736 && view_pitch_i >= -16'sd25736))
    else $error("angle out of range");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(view_x_i) &&
                                      $stable(view_yaw_i)))
    else $error("stalled result changed");

endmodule

bind smoothed_look_at_follower_unit sluf_checker u_sluf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .view_x_i     (view_x_o),
  .view_yaw_i   (view_yaw_o),
  .view_pitch_i (view_pitch_o)
);

// File: test/smoothed_look_at_follower_checker.sv
// Watches the look-at follower channels, predicts every view word and compares it.
module smoothed_look_at_follower_checker #(
  parameter int unsigned STEPS = sluf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  sluf_pkg::cfg_idx_e cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               mode_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] view_x_i,
  input  logic signed [31:0] view_y_i,
  input  logic signed [31:0] view_z_i,
  input  logic signed [15:0] view_yaw_i,
  input  logic signed [15:0] view_pitch_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sluf_pkg::*;

  localparam longint      HALF_TURN_Q30  = 64'sd1686629713;  // pi/2 in Q2.30
  localparam longint      ANGLE_LIM      = 64'sd25736;       // pi in Q3.13
  localparam longint      UNIT_FRACTION  = 64'sd65536;
  localparam longint      SHRINK_AT      = 64'sd2147483648;
  localparam logic [16:0] RESET_FRACTION = 17'd6554;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
  } view_word_t;

  // camera state and register copies
  longint      off_x, off_y, off_z;
  logic [16:0] frac_cfg;
  longint      cam_x, cam_y, cam_z;
  longint      yaw_q13, pitch_q13;

  view_word_t  view_q[$];
  int unsigned fail_count = 0;

  assign fail_count_o = fail_count;

  // atan(2^-i), Q2.30
  function automatic longint atan_q30(int i);
    case (i)
      0:  return 843314857;
      1:  return 497837829;
      2:  return 263043837;
      3:  return 133525159;
      4:  return 67021687;
      5:  return 33543516;
      6:  return 16775851;
      7:  return 8388437;
      8:  return 4194283;
      9:  return 2097149;
      10: return 1048576;
      11: return 524288;
      12: return 262144;
      13: return 131072;
      14: return 65536;
      15: return 32768;
      16: return 16384;
      17: return 8192;
      18: return 4096;
      19: return 2048;
      20: return 1024;
      21: return 512;
      22: return 256;
      23: return 128;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up, floor shift
  function automatic longint ease_toward(longint cur, longint goal, longint f);
    return cur + (((goal - cur) * f + 64'sd32768) >>> 16);
  endfunction

  function automatic longint quarter_mag(longint v);
    return (v < 0) ? -((-v) >>> 2) : (v >>> 2);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned rem, res, probe;
    rem   = v;
    res   = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // atan2(y, x) by vectoring, result in Q3.13
  function automatic longint cordic_heading(longint y_in, longint x_in);
    longint x, y, t, acc, xs, ys, r;
    x   = x_in;
    y   = y_in;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x   = y;
        y   = -t;
        acc = HALF_TURN_Q30;
      end else begin
        x   = -y;
        y   = t;
        acc = -HALF_TURN_Q30;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + atan_q30(i);
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - atan_q30(i);
      end
    end
    r = (acc + 64'sd65536) >>> 17;
    if (r > ANGLE_LIM) r = ANGLE_LIM;
    if (r < -ANGLE_LIM) r = -ANGLE_LIM;
    return r;
  endfunction

  task automatic track_target(input logic follow, input logic signed [31:0] tx_w,
                              input logic signed [31:0] ty_w, input logic signed [31:0] tz_w,
                              output view_word_t w);
    longint tx, ty, tz, gx, gy, gz, f, dx, dy, dz, ax, az, yaw_t, pitch_t;
    longint unsigned h;
    tx = tx_w;
    ty = ty_w;
    tz = tz_w;
    gx = clamp_word(tx + off_x);
    gy = clamp_word(ty + off_y);
    gz = clamp_word(tz + off_z);
    f  = (longint'(frac_cfg) > UNIT_FRACTION) ? UNIT_FRACTION : longint'(frac_cfg);
    if (follow) begin
      cam_x = ease_toward(cam_x, gx, f);
      cam_y = ease_toward(cam_y, gy, f);
      cam_z = ease_toward(cam_z, gz, f);
    end else begin
      cam_x = gx;
      cam_y = gy;
      cam_z = gz;
    end
    dx    = tx - cam_x;
    dy    = ty - cam_y;
    dz    = tz - cam_z;
    yaw_t = cordic_heading(dx, dz);
    ax    = (dx < 0) ? -dx : dx;
    az    = (dz < 0) ? -dz : dz;
    // keep the squares inside 64 bits
    if (ax >= SHRINK_AT || az >= SHRINK_AT) begin
      dx = quarter_mag(dx);
      dy = quarter_mag(dy);
      dz = quarter_mag(dz);
      ax = (dx < 0) ? -dx : dx;
      az = (dz < 0) ? -dz : dz;
    end
    h = floor_root(longint'(ax) * longint'(ax) + longint'(az) * longint'(az));
    pitch_t = cordic_heading(-dy, longint'(h));
    if (follow) begin
      yaw_q13   = ease_toward(yaw_q13, yaw_t, f);
      pitch_q13 = ease_toward(pitch_q13, pitch_t, f);
    end else begin
      yaw_q13   = yaw_t;
      pitch_q13 = pitch_t;
    end
    w.x     = cam_x[31:0];
    w.y     = cam_y[31:0];
    w.z     = cam_z[31:0];
    w.yaw   = yaw_q13[15:0];
    w.pitch = pitch_q13[15:0];
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    view_word_t want;
    if (!rst_ni) begin
      off_x     = 0;
      off_y     = 0;
      off_z     = 0;
      frac_cfg  = RESET_FRACTION;
      cam_x     = 0;
      cam_y     = 0;
      cam_z     = 0;
      yaw_q13   = 0;
      pitch_q13 = 0;
      view_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OFFSET_X:        off_x = longint'($signed(cfg_data_i));
          CFG_OFFSET_Y:        off_y = longint'($signed(cfg_data_i));
          CFG_OFFSET_Z:        off_z = longint'($signed(cfg_data_i));
          CFG_FOLLOW_FRACTION: frac_cfg = cfg_data_i[16:0];
          default: ;
        endcase
      end
      // results first: a word taken this edge cannot leave this edge
      if (out_valid_i && !out_stall_i) begin
        if (view_q.size() == 0) begin
          $error("view word with no target word pending");
          fail_count++;
        end else begin
          want = view_q.pop_front();
          check_field("view_x", $signed(want.x), view_x_i);
          check_field("view_y", $signed(want.y), view_y_i);
          check_field("view_z", $signed(want.z), view_z_i);
          check_field("view_yaw", $signed(want.yaw), view_yaw_i);
          check_field("view_pitch", $signed(want.pitch), view_pitch_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        track_target(mode_i, target_x_i, target_y_i, target_z_i, want);
        view_q.push_back(want);
      end
      pending_o <= view_q.size();
    end
  end

endmodule

// File: test/smoothed_look_at_follower_unit_tb.sv
// Stimulus and verdict for the smoothed look-at follower unit; checking sits in the checker.
module smoothed_look_at_follower_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sluf_pkg::*;

  localparam int unsigned STEPS           = CORDIC_STEPS_DEF;
  localparam int unsigned LATENCY         = 2 * STEPS + 53;
  localparam int unsigned DRAIN_CYCLES    = 2 * LATENCY;
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned WORDS_PER_PHASE = 154;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;

  // mode bit of a target word
  localparam logic SNAP   = 1'b0;
  localparam logic FOLLOW = 1'b1;

  localparam logic signed [31:0] MAXW = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINW = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sd65536;     // 1.0 in Q16.16

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_e           cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic signed [31:0] target_x, target_y, target_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] view_x, view_y, view_z;
  logic signed [15:0] view_yaw, view_pitch;

  int unsigned        pending;
  int unsigned        fail_count;
  int unsigned        cycles = 0;
  logic               hold_off_req = 1'b0;

  smoothed_look_at_follower_unit #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .target_x_i  (target_x),
    .target_y_i  (target_y),
    .target_z_i  (target_z),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .view_x_o    (view_x),
    .view_y_o    (view_y),
    .view_z_o    (view_z),
    .view_yaw_o  (view_yaw),
    .view_pitch_o(view_pitch)
  );

  smoothed_look_at_follower_checker #(
    .STEPS(STEPS)
  ) u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .mode_i      (mode),
    .target_x_i  (target_x),
    .target_y_i  (target_y),
    .target_z_i  (target_z),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .view_x_i    (view_x),
    .view_y_i    (view_y),
    .view_z_i    (view_z),
    .view_yaw_i  (view_yaw),
    .view_pitch_i(view_pitch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop: far above the slowest legal run (every gap and stall at its longest)
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // sender idle: mostly back to back, sometimes long enough to starve the unit
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 150);
  endfunction

  // receiver stall: the long ones can outlast a whole word of work
  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // ends, zero, small offsets and full-range ones
  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return MINW;
      1:       return MAXW;
      2:       return 32'd0;
      3, 4, 5: return $signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
      default: return $urandom();
    endcase
  endfunction

  // fraction register: zero, exactly one, above one with junk in the upper bits,
  // very slow, or anything in between
  function automatic logic [31:0] pick_fraction();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'h0001_0000;
      2:       return ($urandom() & 32'hFFFE_0000) | 32'h0001_0000 | $urandom_range(1, 32'hFFFF);
      3:       return $urandom_range(1, 2000);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  // a fresh coordinate: mostly near the origin so angles are meaningful
  function automatic logic signed [31:0] fresh_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0:       return MAXW;
          1:       return MINW;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
    endcase
  endfunction

  // all four registers back to back; write enable rises and falls once
  task automatic load_config(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [31:0] frac);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OFFSET_X;
    cfg_data  <= ox;
    @(posedge clk);
    cfg_index <= CFG_OFFSET_Y;
    cfg_data  <= oy;
    @(posedge clk);
    cfg_index <= CFG_OFFSET_Z;
    cfg_data  <= oz;
    @(posedge clk);
    cfg_index <= CFG_FOLLOW_FRACTION;
    cfg_data  <= frac;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // offers one word after an optional gap; returns at the edge that took it with
  // valid still high, so a following word with no gap just changes the payload
  task automatic send_word(input logic md, input logic signed [31:0] tx,
                           input logic signed [31:0] ty, input logic signed [31:0] tz,
                           input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= md;
    target_x <= tx;
    target_y <= ty;
    target_z <= tz;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every view word has come back; the unit is idle then
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver: random stalls, free-running stretches, and one long hold-off that
  // backs the unit up while the sender keeps offering words
  initial begin : drain
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 300)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (stall_len()) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic               md;
    logic signed [31:0] walk_x, walk_y, walk_z;
    bit                 steady;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_OFFSET_X;
    cfg_data  = '0;
    in_valid  = 1'b0;
    mode      = SNAP;
    target_x  = '0;
    target_y  = '0;
    target_z  = '0;
    walk_x    = '0;
    walk_y    = '0;
    walk_z    = '0;
    steady    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // register reset values: no offset, fraction about 0.1
    send_word(SNAP, 0, 0, 0, idle_gap());                         // zero vector, angle 0
    send_word(FOLLOW, 10 * ONE, -3 * ONE, 10 * ONE, idle_gap());
    send_word(SNAP, MAXW, MAXW, MAXW, idle_gap());
    send_word(SNAP, MINW, MINW, MINW, idle_gap());
    send_word(FOLLOW, MAXW, MAXW, MAXW, idle_gap());              // span >= 2^31: halved twice
    finish_phase();

    // extreme offsets, fraction exactly one: goal saturates on every axis in the first two words
    load_config(MAXW, MINW, MAXW, 32'h0001_0000);
    send_word(SNAP, 32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000, idle_gap());
    send_word(FOLLOW, MAXW, MINW, MAXW, idle_gap());
    send_word(FOLLOW, MINW, MAXW, MINW, idle_gap());
    send_word(SNAP, MINW, MINW, MINW, idle_gap());
    finish_phase();

    // all data bits set: fraction field above one acts as one; camera behind target
    load_config(32'd0, 32'd0, -(4 * ONE), 32'hFFFF_FFFF);
    send_word(SNAP, 0, 0, 0, idle_gap());
    send_word(FOLLOW, 3 * ONE, 2 * ONE, 0, idle_gap());
    send_word(FOLLOW, MAXW, MINW, MAXW, idle_gap());
    finish_phase();

    // camera in front of target (dz < 0, both signs of dx); fraction zero freezes
    load_config(3 * ONE, 2 * ONE, 4 * ONE, 32'd0);
    send_word(SNAP, 0, 0, 0, idle_gap());
    send_word(FOLLOW, 5 * ONE, 0, 0, idle_gap());
    send_word(SNAP, MINW, MINW, MINW, idle_gap());
    finish_phase();

    // yaw just below +pi, then a follow step to just above -pi: the stored
    // angle is blended straight through zero, no wrap
    load_config(-32'sd6554, 32'd0, 4 * ONE, 32'd32768);
    send_word(SNAP, 0, 0, 0, idle_gap());
    send_word(FOLLOW, -(2 * ONE), 0, 0, idle_gap());
    finish_phase();

    // dx = 0 with dz < 0 gives yaw of pi, clamped; huge dy drives pitch to -pi/2
    load_config(32'd0, MINW, 4 * ONE, 32'h0001_0000);
    send_word(SNAP, 0, 0, 0, idle_gap());
    send_word(FOLLOW, 0, 0, 0, idle_gap());
    finish_phase();

    // ---- random ----
    // a new register setting per phase; most words track a target that wanders
    // in small steps, the rest jump anywhere
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_config(pick_offset(), pick_offset(), pick_offset(), pick_fraction());
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (p == 1 && n == 5) hold_off_req <= 1'b1;
        md = ($urandom_range(0, 99) < 85) ? FOLLOW : SNAP;
        if ($urandom_range(0, 9) < 6) begin
          walk_x = walk_x + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
          walk_y = walk_y + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
          walk_z = walk_z + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
        end else begin
          walk_x = fresh_coord();
          walk_y = fresh_coord();
          walk_z = fresh_coord();
        end
        send_word(md, walk_x, walk_y, walk_z, steady ? 0 : idle_gap());
      end
      finish_phase();
    end

    // nothing is outstanding; give a stray word time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
sv/sluf_pkg.sv
sv/sluf_cordic.sv
sv/sluf_isqrt.sv
sv/smoothed_look_at_follower_unit.sv
sv/sluf_checker.sv
test/smoothed_look_at_follower_checker.sv
test/smoothed_look_at_follower_unit_tb.sv
